// File: hdl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer package
// Shared phase and result kind codes and the fixed frame constants.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // Receive phases of the deframer.
  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LENHI   = 3'd2,
    PH_LENLO   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  // Input mode codes.
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  localparam logic [7:0]  SYNC_FIRST        = 8'hBE;
  localparam logic [7:0]  SYNC_SECOND       = 8'hEF;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'h0208;

endpackage

// File: hdl/slcd_in_if.sv
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel carrying one received byte or a read timeout event.
// ----------------------------------------------------------------------------
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// File: hdl/slcd_out_if.sv
// ----------------------------------------------------------------------------
// Deframer output channel
// Valid/ready channel carrying one payload byte or one frame status.
// ----------------------------------------------------------------------------
interface slcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic [15:0] count;

  modport source (output valid, output kind, output data, output count, input ready);
  modport sink   (input valid, input kind, input data, input count, output ready);
endinterface

// File: hdl/sync_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer
// The block takes one request per clock: a received byte or a read timeout.
// It hunts for the sync pair 0xBE 0xEF, reads a big-endian 16-bit length,
// passes each payload byte out with its index in the frame, and checks the
// trailing byte against the modulo-256 sum of sync, length and payload bytes.
// It reports frame good with the length, or frame dropped on a timeout, an
// oversize length or a checksum mismatch, and then hunts again. An accepted
// request sits in the input register while the decode logic works on it, and
// its result, if any, lands in the output register when the decode stage
// advances, which it does while the output register is free or being drained;
// one request per cycle is sustained while the output side keeps taking
// results. Write max_payload only while no request is in flight.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer
  import slcd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  slcd_in_if.sink      in_i,
  slcd_out_if.source   out_o
);

  // Configuration register.
  logic [15:0] max_payload_q;

  // Input stage.
  logic       in_valid_q;
  logic       in_mode_q;
  logic [7:0] in_byte_q;

  // Frame state.
  phase_e      phase_q, phase_d;
  logic [7:0]  sum_acc_q, sum_acc_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [15:0] byte_index_q, byte_index_d;

  // Output stage.
  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [7:0]  out_data_q;
  logic [15:0] out_count_q;

  // Decode results.
  logic        res_valid;
  kind_e       res_kind;
  logic [7:0]  res_data;
  logic [15:0] res_count;
  logic [7:0]  sum_plus;
  logic [15:0] length_full;
  logic [15:0] index_next;

  logic advance;
  logic process;
  logic load;

  // The decode stage moves when the output register is free or being drained.
  assign advance  = !out_valid_q || out_o.ready;
  assign process  = in_valid_q && advance;
  assign load     = process && res_valid;
  assign in_i.ready = !in_valid_q || advance;

  assign sum_plus    = sum_acc_q + in_byte_q;
  assign length_full = {length_high_q, in_byte_q};
  assign index_next  = byte_index_q + 16'd1;

  // Next frame state and the result caused by the registered request.
  always_comb begin
    phase_d        = phase_q;
    sum_acc_d      = sum_acc_q;
    length_high_d  = length_high_q;
    frame_length_d = frame_length_q;
    byte_index_d   = byte_index_q;
    res_valid      = 1'b0;
    res_kind       = KIND_DROP;
    res_data       = 8'd0;
    res_count      = 16'd0;
    if (in_mode_q == MODE_TIMEOUT) begin
      unique case (phase_q)
        PH_HUNT1: ;
        PH_HUNT2: phase_d = PH_HUNT1;
        PH_LENHI, PH_LENLO, PH_PAYLOAD, PH_CHECK: begin
          phase_d   = PH_HUNT1;
          res_valid = 1'b1;
        end
        default: phase_d = PH_HUNT1;
      endcase
    end else begin
      unique case (phase_q)
        PH_HUNT2: begin
          if (in_byte_q == SYNC_SECOND) begin
            sum_acc_d = sum_plus;
            phase_d   = PH_LENHI;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_LENHI: begin
          sum_acc_d     = sum_plus;
          length_high_d = in_byte_q;
          phase_d       = PH_LENLO;
        end
        PH_LENLO: begin
          sum_acc_d      = sum_plus;
          frame_length_d = length_full;
          byte_index_d   = 16'd0;
          if (length_full > max_payload_q) begin
            phase_d   = PH_HUNT1;
            res_valid = 1'b1;
          end else if (length_full == 16'd0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_acc_d    = sum_plus;
          byte_index_d = index_next;
          if (index_next >= frame_length_q) begin
            phase_d = PH_CHECK;
          end
          res_valid = 1'b1;
          res_kind  = KIND_BYTE;
          res_data  = in_byte_q;
          res_count = byte_index_q;
        end
        PH_CHECK: begin
          phase_d   = PH_HUNT1;
          res_valid = 1'b1;
          if (in_byte_q == sum_acc_q) begin
            res_kind  = KIND_GOOD;
            res_count = frame_length_q;
          end
        end
        default: begin
          // Hunting the first sync byte.
          phase_d = PH_HUNT1;
          if (in_byte_q == SYNC_FIRST) begin
            sum_acc_d = SYNC_FIRST;
            phase_d   = PH_HUNT2;
          end
        end
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_mode_q <= in_i.mode;
      in_byte_q <= in_i.rx_byte;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT1;
      sum_acc_q      <= 8'd0;
      length_high_q  <= 8'd0;
      frame_length_q <= 16'd0;
      byte_index_q   <= 16'd0;
    end else if (process) begin
      phase_q        <= phase_d;
      sum_acc_q      <= sum_acc_d;
      length_high_q  <= length_high_d;
      frame_length_q <= frame_length_d;
      byte_index_q   <= byte_index_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= res_kind;
      out_data_q  <= res_data;
      out_count_q <= res_count;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.kind  = out_kind_q;
  assign out_o.data  = out_data_q;
  assign out_o.count = out_count_q;

  // The payload index always stays below the frame length.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> byte_index_q < frame_length_q)
    else $error("payload index reached frame length");

  // By the checksum byte every payload byte has been counted.
  a_check_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHECK |-> byte_index_q == frame_length_q)
    else $error("checksum phase with missing payload bytes");

  // A frame status always sends the deframer back to hunting.
  a_status_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (res_kind == KIND_GOOD || res_kind == KIND_DROP) |=> phase_q == PH_HUNT1)
    else $error("frame status without return to hunting");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer testbench
// A queue of received bytes and read timeouts drives the input channel, with
// random gaps and random output back-pressure. A request-level predictor
// tracks the hunt, length, payload and checksum phases, and the monitor
// compares every payload byte and frame status with the predicted stream.
// max_payload is rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
module tb;
  import slcd_pkg::*;

  localparam int IDLE_PCT     = 26;
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;

  // Defect injected into a generated frame.
  localparam int FLAW_NONE     = 0;
  localparam int FLAW_BAD_SUM  = 1;
  localparam int FLAW_TIMEOUT  = 2;
  localparam int FLAW_OVERSIZE = 3;

  typedef struct packed {
    logic       mode;
    logic [7:0] b;
  } rx_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] count;
  } deframe_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  slcd_in_if  rx_ch ();
  slcd_out_if res_ch ();

  sync_length_checksum_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (rx_ch),
    .out_o       (res_ch)
  );

  rx_item_t        rx_pending[$];
  deframe_result_t events_due[$];

  int   n_queued;
  int   n_rx_sent;
  int   n_rx_taken;
  int   mismatches;
  int   quiet_cycles;
  logic rx_taken;
  logic calm;

  // Predictor state and its copy of the register.
  phase_e      rx_phase;
  logic [7:0]  chk_sum;
  logic [7:0]  len_high;
  logic [15:0] frame_len;
  logic [15:0] pay_idx;
  logic [15:0] max_len;

  // No random idling on either side for a stretch in the middle of the run.
  assign calm = (n_rx_taken >= 900) && (n_rx_taken < 1200);

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advance the predictor by one request and record the result it causes.
  task automatic deframe_step(input logic mode, input logic [7:0] b);
    deframe_result_t r;
    logic            hit;
    r     = '0;
    r.kind = KIND_DROP;
    hit   = 1'b0;
    if (mode == MODE_TIMEOUT) begin
      case (rx_phase)
        PH_HUNT1: ;
        PH_HUNT2: rx_phase = PH_HUNT1;
        default: begin
          hit      = 1'b1;
          rx_phase = PH_HUNT1;
        end
      endcase
    end else begin
      case (rx_phase)
        PH_HUNT1: begin
          if (b == SYNC_FIRST) begin
            chk_sum  = SYNC_FIRST;
            rx_phase = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (b == SYNC_SECOND) begin
            chk_sum  = chk_sum + b;
            rx_phase = PH_LENHI;
          end else begin
            rx_phase = PH_HUNT1;
          end
        end
        PH_LENHI: begin
          chk_sum  = chk_sum + b;
          len_high = b;
          rx_phase = PH_LENLO;
        end
        PH_LENLO: begin
          chk_sum   = chk_sum + b;
          frame_len = {len_high, b};
          pay_idx   = '0;
          if (frame_len > max_len) begin
            hit      = 1'b1;
            rx_phase = PH_HUNT1;
          end else begin
            rx_phase = (frame_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          hit     = 1'b1;
          r.kind  = KIND_BYTE;
          r.data  = b;
          r.count = pay_idx;
          chk_sum = chk_sum + b;
          pay_idx = pay_idx + 16'd1;
          if (pay_idx >= frame_len) rx_phase = PH_CHECK;
        end
        default: begin
          hit      = 1'b1;
          rx_phase = PH_HUNT1;
          if (b == chk_sum) begin
            r.kind  = KIND_GOOD;
            r.count = frame_len;
          end
        end
      endcase
    end
    if (hit) events_due.push_back(r);
  endtask

  task automatic push_rx(input logic mode, input logic [7:0] b);
    rx_item_t it;
    it.mode = mode;
    it.b    = b;
    rx_pending.push_back(it);
    n_queued++;
  endtask

  // Queue one frame with random payload, optionally broken in one way.
  task automatic queue_frame(input logic [15:0] len, input int flaw);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    int         cut;
    sum = '0;
    bytes_q.push_back(SYNC_FIRST);
    bytes_q.push_back(SYNC_SECOND);
    bytes_q.push_back(len[15:8]);
    bytes_q.push_back(len[7:0]);
    if (flaw != FLAW_OVERSIZE) begin
      for (int i = 0; i < len; i++) bytes_q.push_back(8'($urandom_range(0, 255)));
      foreach (bytes_q[i]) sum = sum + bytes_q[i];
      if (flaw == FLAW_BAD_SUM) begin
        bytes_q.push_back(8'(sum + $urandom_range(1, 255)));
      end else begin
        bytes_q.push_back(sum);
      end
    end
    cut = bytes_q.size();
    if (flaw == FLAW_TIMEOUT) cut = $urandom_range(2, bytes_q.size() - 1);
    for (int i = 0; i < cut; i++) push_rx(MODE_BYTE, bytes_q[i]);
    if (flaw == FLAW_TIMEOUT) push_rx(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  // One random burst: mostly frames, some broken, some line noise.
  task automatic queue_random_burst();
    int          r;
    logic [15:0] cap;
    logic [15:0] len;
    logic [7:0]  b2;
    r   = $urandom_range(0, 99);
    cap = (max_len < 16'd12) ? max_len : 16'd12;
    if ($urandom_range(0, 9) == 0) cap = (max_len < 16'd64) ? max_len : 16'd64;
    len = 16'($urandom_range(0, cap));
    if (r < 60) begin
      queue_frame(len, FLAW_NONE);
    end else if (r < 70) begin
      queue_frame(len, FLAW_BAD_SUM);
    end else if (r < 78 && max_len != 16'hFFFF) begin
      queue_frame(16'($urandom_range(max_len + 1, 65535)), FLAW_OVERSIZE);
    end else if (r < 86) begin
      queue_frame(len, FLAW_TIMEOUT);
    end else if (r < 93) begin
      push_rx(MODE_BYTE, SYNC_FIRST);
      if ($urandom_range(0, 2) == 0) begin
        push_rx(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
      end else begin
        b2 = 8'($urandom_range(0, 255));
        if (b2 == SYNC_SECOND) b2 = SYNC_FIRST;
        push_rx(MODE_BYTE, b2);
      end
    end else begin
      repeat ($urandom_range(1, 4))
        push_rx($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
    end
  endtask

  // Hold off until every request is taken and every result has come back.
  task automatic wait_drained();
    while (!(rx_pending.size() == 0 && n_rx_sent == n_rx_taken &&
             events_due.size() == 0))
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) queue_random_burst();
    // A trailing timeout leaves the framer hunting before the next write.
    push_rx(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic write_max_payload(input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    max_len      = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Main sequence: reset, directed cases, then random phases per setting.
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    rx_ch.valid    = 1'b0;
    rx_ch.mode     = MODE_BYTE;
    rx_ch.rx_byte  = '0;
    res_ch.ready   = 1'b0;
    n_queued       = 0;
    n_rx_sent      = 0;
    n_rx_taken     = 0;
    mismatches     = 0;
    rx_phase       = PH_HUNT1;
    chk_sum        = '0;
    len_high       = '0;
    frame_len      = '0;
    pay_idx        = '0;
    max_len        = MAX_PAYLOAD_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Timeout while hunting, then a timeout as the second sync byte.
    push_rx(MODE_TIMEOUT, 8'hFF);
    push_rx(MODE_BYTE, SYNC_FIRST);
    push_rx(MODE_TIMEOUT, 8'h00);
    // A repeated first sync byte is not looked at again.
    push_rx(MODE_BYTE, SYNC_FIRST);
    push_rx(MODE_BYTE, SYNC_FIRST);
    push_rx(MODE_BYTE, SYNC_SECOND);
    // Zero length goes straight to the checksum byte.
    queue_frame(16'd0, FLAW_NONE);
    // Payload bytes at both extremes.
    push_rx(MODE_BYTE, SYNC_FIRST);
    push_rx(MODE_BYTE, SYNC_SECOND);
    push_rx(MODE_BYTE, 8'h00);
    push_rx(MODE_BYTE, 8'h02);
    push_rx(MODE_BYTE, 8'h00);
    push_rx(MODE_BYTE, 8'hFF);
    push_rx(MODE_BYTE, 8'(SYNC_FIRST + SYNC_SECOND + 8'h02 + 8'hFF));
    // One byte over the reset limit, then a timeout in the length field.
    queue_frame(MAX_PAYLOAD_RESET + 16'd1, FLAW_OVERSIZE);
    push_rx(MODE_BYTE, SYNC_FIRST);
    push_rx(MODE_BYTE, SYNC_SECOND);
    push_rx(MODE_TIMEOUT, 8'h5A);

    run_random(300);
    write_max_payload(16'd0);
    run_random(150);
    write_max_payload(16'hFFFF);
    queue_frame(MAX_PAYLOAD_RESET + 16'd1, FLAW_NONE);
    run_random(250);
    write_max_payload(16'd7);
    run_random(300);
    write_max_payload(16'($urandom_range(1, 40)));
    run_random(300);

    repeat (10) @(posedge clk_i);
    if (events_due.size() != 0) begin
      $display("missing results: %0d still expected", events_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Request driver and result back-pressure, both on the falling edge.
  always @(negedge clk_i) begin : drive_rx
    rx_item_t it;
    if (rst_ni && (!rx_ch.valid || rx_taken)) begin
      if (rx_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        it = rx_pending.pop_front();
        rx_ch.valid   <= 1'b1;
        rx_ch.mode    <= it.mode;
        rx_ch.rx_byte <= it.b;
        n_rx_sent++;
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= rst_ni && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: check results, feed accepted requests to the predictor.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    deframe_result_t got;
    deframe_result_t want;
    if (!rst_ni) begin
      rx_taken <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind  = kind_e'(res_ch.kind);
        got.data  = res_ch.data;
        got.count = res_ch.count;
        if (events_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result: kind=%0d data=%02h count=%0d",
                     got.kind, got.data, got.count);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.count !== want.count) begin
            if (mismatches < REPORT_LIMIT)
              $display({"mismatch: expected kind=%0d data=%02h count=%0d, ",
                        "got kind=%0d data=%02h count=%0d"},
                       want.kind, want.data, want.count,
                       got.kind, got.data, got.count);
            mismatches++;
          end
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        deframe_step(rx_ch.mode, rx_ch.rx_byte);
        n_rx_taken++;
      end
      rx_taken <= rx_ch.valid && rx_ch.ready;
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: files.f
hdl/slcd_pkg.sv
hdl/slcd_in_if.sv
hdl/slcd_out_if.sv
hdl/sync_length_checksum_deframer.sv
tb/tb.sv
